// ----- rtl/bitmap_page_allocator_defines.svh -----
// Assertion shorthands for the page allocator.
// Each expects clk and rst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpa_pkg.sv -----
`default_nettype none

package bpa_pkg;

    localparam int ADDR_W      = 48;
    localparam int PAGES_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = ((ADDR_W + PAGES_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_OUTSIDE    = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_BASE  = 2'd0,
        REG_REGION_PAGES = 2'd1
    } cfg_reg_t;

    // control from the sequencer to the run detector
    typedef struct packed {
        logic clear;   // restart run count
        logic step;    // a bitmap bit is presented
        logic used;    // that bit
    } scan_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
`default_nettype none

// simple dual-port RAM, registered read
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bpa_run_det.sv -----
`default_nettype none

// free-run detector: counts consecutive free pages, one bit a cycle
module bpa_run_det #(
    parameter int PAGE_W  = 12,
    parameter int COUNT_W = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bpa_pkg::scan_ctl_t ctl,
    input  wire logic [PAGE_W-1:0]  page,
    input  wire logic [COUNT_W-1:0] need,
    output logic                    hit,
    output logic      [PAGE_W-1:0]  run_start
);

    logic [COUNT_W-1:0] run_reg;
    logic [COUNT_W-1:0] run_next;
    logic [PAGE_W-1:0]  first_reg;
    logic [PAGE_W-1:0]  first_next;
    logic [COUNT_W-1:0] run_inc;

    assign run_inc   = run_reg + COUNT_W'(1);
    assign run_start = (run_reg == '0) ? page : first_reg;
    assign hit       = ctl.step && !ctl.used && (run_inc == need);

    always_comb
    begin
        run_next   = run_reg;
        first_next = first_reg;
        if (ctl.clear)
        begin
            run_next = '0;
        end
        else if (ctl.step)
        begin
            if (ctl.used)
            begin
                run_next = '0;
            end
            else
            begin
                run_next   = run_inc;
                first_next = run_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tuser: command; s_tdata: address, page_count
// m_*       out  m_tvalid/m_tready    m_tdata: page_address, status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (region_base, region_pages)
//
// Allocate: size checks, then S pages scanned (up to twice the live
//   region when the search wraps), then N pages marked; one bitmap bit a cycle.
// Free: offset and range checks, then N pages cleared through the single write port.
// Reset: clearing pass over every bitmap page; no request taken meanwhile.
// A result waits in the output register; the next request is taken once the
// sequencer is idle, and finishing it stalls only while that register is full.
`default_nettype none

`include "bitmap_page_allocator_defines.svh"

module bitmap_page_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // request
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [bpa_pkg::IN_TDATA_W-1:0]       s_tdata,  // address, page_count
    input  wire logic [0:0]                           s_tuser,  // command
    // result
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [bpa_pkg::OUT_TDATA_W-1:0]      m_tdata,  // page_address, status
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bpa_pkg::ADDR_W-1:0]           cfg_data
);

    localparam int AW = bpa_pkg::ADDR_W;
    localparam int TW = bpa_pkg::PAGES_W;
    localparam int PW = $clog2(MAX_PAGES);       // page index
    localparam int CW = $clog2(MAX_PAGES + 1);   // page count
    localparam int LW = (CW > TW) ? CW : TW;     // common compare width
    localparam int PADW = bpa_pkg::OUT_TDATA_W - AW - bpa_pkg::STATUS_W;

    // one-hot sequencer
    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,  // bitmap clearing pass
        S_IDLE = 8'b0000_0010,
        S_ACHK = 8'b0000_0100,  // allocate size checks
        S_FCHK = 8'b0000_1000,  // free: offset from base
        S_FRNG = 8'b0001_0000,  // free: range check and clip
        S_SCAN = 8'b0010_0000,  // bitmap walk
        S_MARK = 8'b0100_0000,  // set or clear a run of bits
        S_DONE = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t                 state_reg, state_next;

    // configuration
    logic [AW-1:0]          base_reg;
    logic [TW-1:0]          pages_reg;

    // request
    bpa_pkg::cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [TW-1:0]          count_reg, count_next;
    logic [CW-1:0]          total_reg, total_next;

    // allocator state
    logic [PW-1:0]          cursor_reg, cursor_next;

    // scan pipeline
    logic [PW-1:0]          p_reg, p_next;     // read address issued
    logic [PW-1:0]          q_reg, q_next;     // page whose bit is in rdata
    logic                   v_reg, v_next;
    logic                   retry_reg, retry_next;

    // write sweep
    logic [PW-1:0]          m_reg, m_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic                   wbit_reg, wbit_next;
    logic [PW-1:0]          first_reg, first_next;

    // free range check
    logic [AW-1:0]          off_reg, off_next;
    logic                   below_reg, below_next;

    // result staging and output
    logic [AW-1:0]          res_addr_reg, res_addr_next;
    bpa_pkg::status_t       res_status_reg, res_status_next;
    logic [AW-1:0]          out_addr_reg, out_addr_next;
    bpa_pkg::status_t       out_status_reg, out_status_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [CW-1:0]          live_w;
    logic [CW-1:0]          need_w;
    logic [AW-1:0]          pg_w;
    logic [PW-1:0]          start_w;
    logic [CW-1:0]          avail_w;
    logic [CW-1:0]          free_n_w;
    logic [CW-1:0]          sum_w;
    logic [PW-1:0]          cur_w;
    logic                   in_fire;

    // bitmap RAM
    logic                   ram_we;
    logic [PW-1:0]          ram_waddr;
    logic [0:0]             ram_wdata;
    logic [0:0]             ram_rdata;

    // run detector
    bpa_pkg::scan_ctl_t     run_ctl;
    logic                   run_hit;
    logic [PW-1:0]          run_first;

    bpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (p_reg),
        .rdata (ram_rdata)
    );

    bpa_run_det #(
        .PAGE_W  (PW),
        .COUNT_W (CW)
    ) u_run (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (run_ctl),
        .page      (q_reg),
        .need      (need_w),
        .hit       (run_hit),
        .run_start (run_first)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {PADW'(0), out_status_reg, out_addr_reg};

    // live region is clipped to the bitmap size
    assign live_w   = (LW'(pages_reg) > LW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_reg);
    assign need_w   = CW'(count_reg);
    assign pg_w     = off_reg >> PAGE_SHIFT;
    assign start_w  = PW'(pg_w);
    assign avail_w  = total_reg - CW'(start_w);
    assign free_n_w = (LW'(count_reg) > LW'(avail_w)) ? avail_w : CW'(count_reg);
    assign sum_w    = CW'(run_first) + need_w;
    // a cursor left beyond a shrunken region restarts at page 0
    assign cur_w    = (CW'(cursor_reg) >= total_reg) ? '0 : cursor_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        cursor_next     = cursor_reg;
        p_next          = p_reg;
        q_next          = p_reg;
        v_next          = 1'b0;
        retry_next      = retry_reg;
        m_next          = m_reg;
        rem_next        = rem_reg;
        wbit_next       = wbit_reg;
        first_next      = first_reg;
        off_next        = off_reg;
        below_next      = below_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_waddr       = m_reg;
        ram_wdata       = 1'b0;
        run_ctl         = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                m_next = m_reg + PW'(1);
                if (m_reg == PW'(MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = bpa_pkg::cmd_t'(s_tuser[0]);
                    addr_next       = s_tdata[AW-1:0];
                    count_next      = s_tdata[AW+TW-1:AW];
                    total_next      = live_w;
                    res_addr_next   = '0;
                    res_status_next = bpa_pkg::ST_ALLOC_FAIL;
                    if (bpa_pkg::cmd_t'(s_tuser[0]) == bpa_pkg::CMD_FREE)
                    begin
                        state_next = S_FCHK;
                    end
                    else
                    begin
                        state_next = S_ACHK;
                    end
                end
            end

            S_ACHK:
            begin
                if (count_reg == '0 || total_reg == '0 || LW'(count_reg) > LW'(total_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next        = cur_w;
                    retry_next    = (cur_w != '0);
                    run_ctl.clear = 1'b1;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                p_next = p_reg + PW'(1);
                v_next = 1'b1;
                if (v_reg)
                begin
                    run_ctl.step = 1'b1;
                    run_ctl.used = ram_rdata[0];
                    if (run_hit)
                    begin
                        m_next          = run_first;
                        first_next      = run_first;
                        rem_next        = need_w;
                        wbit_next       = 1'b1;
                        cursor_next     = (sum_w == total_reg) ? '0 : PW'(sum_w);
                        res_status_next = bpa_pkg::ST_OK;
                        state_next      = S_MARK;
                    end
                    else if (CW'(q_reg) == total_reg - CW'(1))
                    begin
                        // end of pass: wrap once to page 0, runs never cross
                        if (retry_reg)
                        begin
                            retry_next    = 1'b0;
                            p_next        = '0;
                            v_next        = 1'b0;
                            run_ctl.clear = 1'b1;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = wbit_reg;
                m_next    = m_reg + PW'(1);
                rem_next  = rem_reg - CW'(1);
                if (wbit_reg)
                begin
                    res_addr_next = base_reg + (AW'(first_reg) << PAGE_SHIFT);
                end
                if (rem_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_FCHK:
            begin
                off_next   = addr_reg - base_reg;
                below_next = (addr_reg < base_reg);
                state_next = S_FRNG;
            end

            S_FRNG:
            begin
                if (below_reg || total_reg == '0 || pg_w >= AW'(total_reg))
                begin
                    res_status_next = bpa_pkg::ST_OUTSIDE;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_status_next = bpa_pkg::ST_OK;
                    if (start_w < cursor_reg)
                    begin
                        cursor_next = start_w;
                    end
                    m_next    = start_w;
                    rem_next  = free_n_w;
                    wbit_next = 1'b0;
                    if (free_n_w == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= '0;
            pages_reg     <= TW'(4096);
            cursor_reg    <= '0;
            m_reg         <= '0;
            v_reg         <= 1'b0;
            retry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            m_reg         <= m_next;
            v_reg         <= v_next;
            retry_reg     <= retry_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bpa_pkg::REG_REGION_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == bpa_pkg::REG_REGION_PAGES)
                begin
                    pages_reg <= cfg_data[TW-1:0];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        count_reg      <= count_next;
        total_reg      <= total_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        wbit_reg       <= wbit_next;
        first_reg      <= first_next;
        off_reg        <= off_next;
        below_reg      <= below_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    `BPA_ASSERT_NEXT(a_request_starts_check, in_fire, state_reg == S_ACHK || state_reg == S_FCHK, "request accepted but sequencer did not start")
    `BPA_ASSERT_IMPL(a_sweep_not_empty, state_reg == S_MARK, rem_reg != '0, "write sweep entered with nothing to write")
    `BPA_ASSERT_IMPL(a_hit_in_region, state_reg == S_SCAN && run_hit && cmd_reg == bpa_pkg::CMD_ALLOC, CW'(run_first) < total_reg, "run found outside live region")
    `BPA_ASSERT_NEXT(a_result_waits, state_reg == S_DONE && out_valid_reg && !m_tready, state_reg == S_DONE, "result overwrote an untaken one")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_PAGES      = 4096;
    localparam int PAGE_SHIFT     = 12;
    // longest stretch with no handshake on any channel: clearing pass after
    // reset, or a failing allocate scanning the region twice, plus a stall
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLDOFF_AFTER  = 40;   // results seen before the long hold-off
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DIRECTED_ROWS  = 21;

    typedef struct packed {
        logic [bpa_pkg::ADDR_W-1:0] page_address;
        bpa_pkg::status_t           status;
    } page_result_t;

    typedef struct {
        logic [bpa_pkg::ADDR_W-1:0]  addr;
        logic [bpa_pkg::PAGES_W-1:0] count;
    } page_run_t;

    // one directed request; want_* only used where typed is set
    typedef struct packed {
        bpa_pkg::cmd_t               cmd;
        logic [bpa_pkg::ADDR_W-1:0]  addr;
        logic [bpa_pkg::PAGES_W-1:0] count;
        logic                        typed;
        logic [bpa_pkg::ADDR_W-1:0]  want_addr;
        bpa_pkg::status_t            want_status;
    } request_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bpa_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // address [47:0], page_count [60:48]
    logic [0:0]                      s_tuser = '0;   // command
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bpa_pkg::OUT_TDATA_W-1:0] m_tdata;        // page_address [47:0], status [49:48]
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index = bpa_pkg::REG_REGION_BASE;
    logic [bpa_pkg::ADDR_W-1:0]      cfg_data = '0;

    // shadow state of the allocator
    logic                            page_used [MAX_PAGES];
    int unsigned                     cursor_page;
    logic [bpa_pkg::ADDR_W-1:0]      region_base_q;
    logic [bpa_pkg::PAGES_W-1:0]     region_pages_q;

    page_result_t                    pending_results [$];
    page_run_t                       granted_runs [$];
    int                              mismatch_count;
    int                              results_seen;
    int                              stall_cycles;
    bit                              calm;           // no idling on either side
    bit                              holdoff_done;

    // Typed rows: outcome obvious from reset state, extremes or error codes.
    // Others go through the shadow model.
    request_row_t directed_rows [DIRECTED_ROWS] = '{
        // zero pages
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd0, 1'b1, 48'h0, bpa_pkg::ST_ALLOC_FAIL},
        // count all ones
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd8191, 1'b1, 48'h0, bpa_pkg::ST_ALLOC_FAIL},
        // bigger than region
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd4097, 1'b1, 48'h0, bpa_pkg::ST_ALLOC_FAIL},
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd1, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // fills it, cursor wraps
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd4095, 1'b1, 48'h1000, bpa_pkg::ST_OK},
        // region full
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd1, 1'b1, 48'h0, bpa_pkg::ST_ALLOC_FAIL},
        // pages 0..2
        '{bpa_pkg::CMD_FREE, 48'h0, 13'd3, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // clipped at end
        '{bpa_pkg::CMD_FREE, 48'hFFE000, 13'd8191, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // unaligned, 100..109
        '{bpa_pkg::CMD_FREE, 48'h64123, 13'd10, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // skips short hole
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd8, 1'b0, 48'h0, bpa_pkg::ST_OK},
        // no run across wrap
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd4, 1'b0, 48'h0, bpa_pkg::ST_OK},
        // found below cursor
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd3, 1'b0, 48'h0, bpa_pkg::ST_OK},
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd2, 1'b0, 48'h0, bpa_pkg::ST_OK},
        // one past region
        '{bpa_pkg::CMD_FREE, 48'h1000000, 13'd1, 1'b1, 48'h0, bpa_pkg::ST_OUTSIDE},
        '{bpa_pkg::CMD_FREE, 48'hFFFFFFFFFFFF, 13'd8191, 1'b1, 48'h0, bpa_pkg::ST_OUTSIDE},
        // zero-page free
        '{bpa_pkg::CMD_FREE, 48'h0, 13'd0, 1'b1, 48'h0, bpa_pkg::ST_OK},
        '{bpa_pkg::CMD_FREE, 48'h5000, 13'd0, 1'b0, 48'h0, bpa_pkg::ST_OK},
        // whole region
        '{bpa_pkg::CMD_FREE, 48'h0, 13'd4096, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // whole region
        '{bpa_pkg::CMD_ALLOC, 48'h0, 13'd4096, 1'b1, 48'h0, bpa_pkg::ST_OK},
        '{bpa_pkg::CMD_FREE, 48'h0, 13'd4096, 1'b1, 48'h0, bpa_pkg::ST_OK},
        // address ignored
        '{bpa_pkg::CMD_ALLOC, 48'hFFFFFFFFFFFF, 13'd4095, 1'b0, 48'h0, bpa_pkg::ST_OK}
    };

    bitmap_page_allocator #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Shadow model
    // ---------------------------------------------------------------------

    function automatic int unsigned live_page_count();
        return (region_pages_q > MAX_PAGES) ? MAX_PAGES : int'(region_pages_q);
    endfunction

    // first page in [lo, total) opening a free run of need pages inside it
    function automatic int unsigned find_free_run(int unsigned lo, int unsigned total,
                                                  int unsigned need);
        int unsigned run_len = 0;
        int unsigned run_start = 0;
        for (int unsigned p = lo; p < total; p++)
        begin
            if (page_used[p])
                run_len = 0;
            else
            begin
                if (run_len == 0)
                    run_start = p;
                run_len++;
                if (run_len == need)
                    return run_start;
            end
        end
        return total;
    endfunction

    function automatic page_result_t predict_request(bpa_pkg::cmd_t cmd,
                                                     logic [bpa_pkg::ADDR_W-1:0] addr,
                                                     logic [bpa_pkg::PAGES_W-1:0] count);
        page_result_t res;
        int unsigned  total;
        int unsigned  from;
        int unsigned  first;
        int unsigned  free_from;
        int unsigned  stop_page;
        logic [63:0]  limit_addr;
        total = live_page_count();
        res.page_address = '0;
        res.status = bpa_pkg::ST_ALLOC_FAIL;
        if (cmd == bpa_pkg::CMD_ALLOC)
        begin
            // cursor past a shrunken region restarts at page 0
            from = (cursor_page >= total) ? 0 : cursor_page;
            if (count != 0 && total != 0 && count <= total)
            begin
                first = find_free_run(from, total, count);
                if (first >= total && from > 0)
                    first = find_free_run(0, total, count);
                if (first < total)
                begin
                    for (int unsigned p = first; p < first + count; p++)
                        page_used[p] = 1'b1;
                    cursor_page = (first + count >= total) ? 0 : first + count;
                    res.page_address = region_base_q + (48'(first) << PAGE_SHIFT);
                    res.status = bpa_pkg::ST_OK;
                    granted_runs.push_back('{res.page_address, count});
                end
            end
        end
        else
        begin
            // region end is not truncated: a region near the top covers the rest
            limit_addr = 64'(region_base_q) + (64'(total) << PAGE_SHIFT);
            if (total == 0 || addr < region_base_q || 64'(addr) >= limit_addr)
                res.status = bpa_pkg::ST_OUTSIDE;
            else
            begin
                free_from = 32'((addr - region_base_q) >> PAGE_SHIFT);
                stop_page = (count > total - free_from) ? total : free_from + count;
                for (int unsigned p = free_from; p < stop_page; p++)
                    page_used[p] = 1'b0;
                if (free_from < cursor_page)
                    cursor_page = free_from;
                res.status = bpa_pkg::ST_OK;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    task automatic send_request(bpa_pkg::cmd_t cmd, logic [bpa_pkg::ADDR_W-1:0] addr,
                                logic [bpa_pkg::PAGES_W-1:0] count, bit typed,
                                page_result_t typed_result);
        page_result_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, count, addr};
        do @(posedge clk); while (!s_tready);
        predicted = predict_request(cmd, addr, count);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(bpa_pkg::cfg_reg_t index,
                                  logic [bpa_pkg::ADDR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            bpa_pkg::REG_REGION_BASE:  region_base_q = value;
            bpa_pkg::REG_REGION_PAGES: region_pages_q = value[bpa_pkg::PAGES_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers only change with the block idle
    task automatic set_region(logic [bpa_pkg::ADDR_W-1:0] base,
                              logic [bpa_pkg::PAGES_W-1:0] pages);
        drain_results();
        write_register(bpa_pkg::REG_REGION_BASE, base);
        write_register(bpa_pkg::REG_REGION_PAGES, 48'(pages));
        granted_runs.delete();
    endtask

    // Mostly allocates and frees of earlier grants, the rest in-region frees
    // at random pages and plain noise.
    task automatic issue_random_requests(int unsigned n);
        int unsigned                 total;
        int unsigned                 small_count;
        int unsigned                 pick;
        int unsigned                 sel;
        int unsigned                 idx;
        logic [63:0]                 noise;
        bpa_pkg::cmd_t               cmd;
        logic [bpa_pkg::ADDR_W-1:0]  addr;
        logic [bpa_pkg::PAGES_W-1:0] count;
        page_run_t                   run;
        repeat (n)
        begin
            total = live_page_count();
            small_count = (total == 0) ? 1 : ((total > 16) ? 16 : total);
            pick = $urandom_range(99);
            sel = $urandom_range(9);
            noise = {$urandom(), $urandom()};
            addr = noise[bpa_pkg::ADDR_W-1:0];
            count = 13'($urandom_range(small_count, 1));
            if (pick < 45)
            begin
                cmd = bpa_pkg::CMD_ALLOC;
                if (sel == 0)
                    count = '0;
                else if (sel == 1)
                    count = 13'($urandom());
                else if (sel == 2)
                    count = 13'(total);
            end
            else if (pick < 85 && total != 0)
            begin
                cmd = bpa_pkg::CMD_FREE;
                if (granted_runs.size() != 0 && sel < 5)
                begin
                    idx = $urandom_range(granted_runs.size() - 1);
                    run = granted_runs[idx];
                    granted_runs.delete(idx);
                    addr = run.addr;
                    count = run.count;
                end
                else
                begin
                    addr = region_base_q + (48'($urandom_range(total - 1)) << PAGE_SHIFT)
                           + 48'($urandom_range(4095));
                    if (sel == 5)
                        count = 13'($urandom());
                    else if (sel == 6)
                        count = '0;
                end
            end
            else
            begin
                cmd = bpa_pkg::cmd_t'($urandom_range(1));
                count = 13'($urandom());
            end
            send_request(cmd, addr, count, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off to fill the block
    // ---------------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AFTER)
            begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_done = 1'b1;
            end
            m_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none pending: expected none, actual %h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[bpa_pkg::ADDR_W-1:0] !== want.page_address)
                begin
                    mismatch_count++;
                    $display("%0t: page_address expected %h actual %h",
                             $time, want.page_address, m_tdata[bpa_pkg::ADDR_W-1:0]);
                end
                if (m_tdata[bpa_pkg::ADDR_W+bpa_pkg::STATUS_W-1:bpa_pkg::ADDR_W]
                    !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status,
                             m_tdata[bpa_pkg::ADDR_W+bpa_pkg::STATUS_W-1:bpa_pkg::ADDR_W]);
                end
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        logic [63:0] noise;
        region_base_q = '0;
        region_pages_q = 13'd4096;
        cursor_page = 0;
        foreach (page_used[p])
            page_used[p] = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: base 0, 4096 pages
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].addr,
                         directed_rows[i].count, directed_rows[i].typed,
                         '{directed_rows[i].want_addr, directed_rows[i].want_status});

        // top of the address space: granted addresses wrap at 48 bits
        set_region(48'hFFFF_FFFF_F000, 13'd4096);
        issue_random_requests(25);

        noise = {$urandom(), $urandom()};
        set_region({noise[bpa_pkg::ADDR_W-1:PAGE_SHIFT], 12'h000}, 13'd1);
        issue_random_requests(12);

        // empty region
        set_region(48'h0, 13'd0);
        issue_random_requests(8);

        // unaligned base, page count above the bitmap size
        noise = {$urandom(), $urandom()};
        set_region(noise[bpa_pkg::ADDR_W-1:0], 13'd8191);
        issue_random_requests(20);

        // small region at full rate on both sides
        calm = 1'b1;
        noise = {$urandom(), $urandom()};
        set_region({noise[bpa_pkg::ADDR_W-1:PAGE_SHIFT], 12'h000},
                   13'($urandom_range(64, 2)));
        issue_random_requests(35);
        calm = 1'b0;

        // shrink: cursor may now lie past the region, pages beyond keep their bits
        set_region(48'h0000_0010_0000, 13'd8);
        issue_random_requests(10);

        set_region(48'h0, 13'd4096);
        issue_random_requests(10);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
